FILE: rtl/cds_pkg.sv
// Package for the membership-checked descending sorter.
// Word, function and tag types and codes; no dependencies.
package cds_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [1:0]         func_t;
  typedef logic [1:0]         tag_t;

  localparam func_t FUNC_LIST   = 2'd0;
  localparam func_t FUNC_CHOICE = 2'd1;
  localparam func_t FUNC_FINISH = 2'd2;

  localparam tag_t TAG_OK          = 2'd0;
  localparam tag_t TAG_NOT_IN_LIST = 2'd1;
  localparam tag_t TAG_FULL        = 2'd2;
  localparam tag_t TAG_SORTED      = 2'd3;

endpackage

FILE: rtl/cds_if.sv
// Valid/ready channel interfaces for the sorter's input and result words.
// Depends on cds_pkg for payload types.
interface cds_in_if;
  logic            valid;
  logic            ready;
  cds_pkg::func_t  func;
  cds_pkg::word_t  value_in;

  modport source (output valid, output func, output value_in, input ready);
  modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface cds_out_if;
  logic            valid;
  logic            ready;
  cds_pkg::tag_t   tag;
  cds_pkg::word_t  value_out;
  logic            last;

  modport source (output valid, output tag, output value_out, output last, input ready);
  modport sink   (input valid, input tag, input value_out, input last, output ready);
endinterface

FILE: rtl/cds_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on cds_pkg for the word type.
module cds_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  cds_pkg::word_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output cds_pkg::word_t rd_data
);

  cds_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/checked_choice_descending_sorter_top.sv
// Top level of the membership-checked descending sorter.
// Depends on cds_pkg, cds_in_if, cds_out_if and cds_ram.
//
// Input words carry func and value_in. A list word appends value_in to the
// reference list and answers with one word (tag accepted or store full). A
// choice word scans the reference list, one entry per cycle, then inserts the
// value into the choice RAM in descending order, each entry moved through a
// read in ST_INS_RD and a write in ST_INS_CMP; it answers with one word
// (accepted, not in list, or store full). A finish word streams the stored
// choices from the choice RAM, largest first, each word read in ST_EM_RD once
// the output register is free and loaded in ST_EM_LD, with last set on the
// final one, then empties the choice store; an empty store gives no words.
// Unused func codes are dropped. A choice word's answer waits on the list
// scan and the insertion shift through the single-read choice RAM. One input
// word is worked on at a time; in_ready is high only while idle, also while a
// finished result still waits in the output register. When the receiver
// stalls, the output register holds its word and the next result waits for it.
// Reset (rst_n low, synchronous) empties both stores and the output register.
module checked_choice_descending_sorter_top #(
  parameter int LIST_DEPTH   = 32,
  parameter int CHOICE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cds_in_if.sink     in_ch,
  cds_out_if.source  out_ch
);

  localparam int LA  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CA  = (CHOICE_DEPTH > 1) ? $clog2(CHOICE_DEPTH) : 1;
  localparam int LCW = $clog2(LIST_DEPTH + 1);
  localparam int CCW = $clog2(CHOICE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_INS_RD  = 3'd2;
  localparam logic [2:0] ST_INS_CMP = 3'd3;
  localparam logic [2:0] ST_EM_RD   = 3'd4;
  localparam logic [2:0] ST_EM_LD   = 3'd5;
  localparam logic [2:0] ST_RESP    = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [LCW-1:0] list_count_r, list_count_nxt;
  logic [CCW-1:0] choice_count_r, choice_count_nxt;
  logic [LCW-1:0] scan_idx_r, scan_idx_nxt;
  logic           pend_r, pend_nxt;
  logic [CCW-1:0] pos_r, pos_nxt;
  logic [CCW-1:0] emit_idx_r, emit_idx_nxt;
  cds_pkg::word_t val_r, val_nxt;
  cds_pkg::tag_t  resp_tag_r, resp_tag_nxt;

  logic           out_valid_r, out_valid_nxt;
  cds_pkg::tag_t  out_tag_r, out_tag_nxt;
  cds_pkg::word_t out_value_r, out_value_nxt;
  logic           out_last_r, out_last_nxt;

  logic           list_we, list_re;
  logic [LA-1:0]  list_waddr, list_raddr;
  cds_pkg::word_t list_q;
  logic           ch_we, ch_re;
  logic [CA-1:0]  ch_waddr, ch_raddr;
  cds_pkg::word_t ch_wdata, ch_q;

  logic           out_free;
  logic           in_acc;
  logic           scan_issue;
  logic [CCW-1:0] pos_dec;

  cds_ram #(.DEPTH(LIST_DEPTH), .AW(LA)) u_list_ram (
    .clk     (clk),
    .wr_en   (list_we),
    .wr_addr (list_waddr),
    .wr_data (in_ch.value_in),
    .rd_en   (list_re),
    .rd_addr (list_raddr),
    .rd_data (list_q)
  );

  cds_ram #(.DEPTH(CHOICE_DEPTH), .AW(CA)) u_choice_ram (
    .clk     (clk),
    .wr_en   (ch_we),
    .wr_addr (ch_waddr),
    .wr_data (ch_wdata),
    .rd_en   (ch_re),
    .rd_addr (ch_raddr),
    .rd_data (ch_q)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_free         = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.tag       = out_tag_r;
  assign out_ch.value_out = out_value_r;
  assign out_ch.last      = out_last_r;

  assign scan_issue = (scan_idx_r < list_count_r);
  assign pos_dec    = pos_r - CCW'(1);
  assign list_waddr = list_count_r[LA-1:0];
  assign list_raddr = scan_idx_r[LA-1:0];

  always_comb begin
    state_nxt        = state_r;
    list_count_nxt   = list_count_r;
    choice_count_nxt = choice_count_r;
    scan_idx_nxt     = scan_idx_r;
    pend_nxt         = 1'b0;
    pos_nxt          = pos_r;
    emit_idx_nxt     = emit_idx_r;
    val_nxt          = val_r;
    resp_tag_nxt     = resp_tag_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_tag_nxt      = out_tag_r;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;
    list_we          = 1'b0;
    list_re          = 1'b0;
    ch_we            = 1'b0;
    ch_waddr         = pos_r[CA-1:0];
    ch_wdata         = val_r;
    ch_re            = 1'b0;
    ch_raddr         = pos_dec[CA-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          val_nxt = in_ch.value_in;
          unique case (in_ch.func)
            cds_pkg::FUNC_LIST: begin
              state_nxt = ST_RESP;
              if (list_count_r == LCW'(LIST_DEPTH)) begin
                resp_tag_nxt = cds_pkg::TAG_FULL;
              end else begin
                resp_tag_nxt   = cds_pkg::TAG_OK;
                list_we        = 1'b1;
                list_count_nxt = list_count_r + LCW'(1);
              end
            end
            cds_pkg::FUNC_CHOICE: begin
              state_nxt    = ST_SCAN;
              scan_idx_nxt = '0;
            end
            cds_pkg::FUNC_FINISH: begin
              if (choice_count_r != '0) begin
                state_nxt    = ST_EM_RD;
                emit_idx_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (pend_r && (list_q == val_r)) begin
          if (choice_count_r == CCW'(CHOICE_DEPTH)) begin
            resp_tag_nxt = cds_pkg::TAG_FULL;
            state_nxt    = ST_RESP;
          end else begin
            pos_nxt   = choice_count_r;
            state_nxt = ST_INS_RD;
          end
        end else if (!scan_issue && !pend_r) begin
          resp_tag_nxt = cds_pkg::TAG_NOT_IN_LIST;
          state_nxt    = ST_RESP;
        end else begin
          list_re      = scan_issue;
          pend_nxt     = scan_issue;
          scan_idx_nxt = scan_idx_r + LCW'(scan_issue);
        end
      end
      ST_INS_RD: begin
        if (pos_r == '0) begin
          ch_we            = 1'b1;
          choice_count_nxt = choice_count_r + CCW'(1);
          resp_tag_nxt     = cds_pkg::TAG_OK;
          state_nxt        = ST_RESP;
        end else begin
          ch_re     = 1'b1;
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        ch_we = 1'b1;
        if (ch_q < val_r) begin
          ch_wdata  = ch_q;
          pos_nxt   = pos_dec;
          state_nxt = ST_INS_RD;
        end else begin
          choice_count_nxt = choice_count_r + CCW'(1);
          resp_tag_nxt     = cds_pkg::TAG_OK;
          state_nxt        = ST_RESP;
        end
      end
      ST_EM_RD: begin
        if (out_free) begin
          ch_re     = 1'b1;
          ch_raddr  = emit_idx_r[CA-1:0];
          state_nxt = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        out_valid_nxt = 1'b1;
        out_tag_nxt   = cds_pkg::TAG_SORTED;
        out_value_nxt = ch_q;
        out_last_nxt  = (emit_idx_r == choice_count_r - CCW'(1));
        if (emit_idx_r == choice_count_r - CCW'(1)) begin
          choice_count_nxt = '0;
          state_nxt        = ST_IDLE;
        end else begin
          emit_idx_nxt = emit_idx_r + CCW'(1);
          state_nxt    = ST_EM_RD;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tag_nxt   = resp_tag_r;
          out_value_nxt = val_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      list_count_r   <= '0;
      choice_count_r <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      list_count_r   <= list_count_nxt;
      choice_count_r <= choice_count_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    pos_r       <= pos_nxt;
    emit_idx_r  <= emit_idx_nxt;
    val_r       <= val_nxt;
    resp_tag_r  <= resp_tag_nxt;
    out_tag_r   <= out_tag_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

FILE: test/cds_tb_pkg.sv
// Scoreboard for the membership-checked descending sorter testbench.
// Depends on cds_pkg for the word, function and tag types and codes.
package cds_tb_pkg;

  localparam int LIST_CAP   = 32;
  localparam int CHOICE_CAP = 32;

  localparam cds_pkg::func_t FUNC_UNUSED = 2'd3;

  typedef struct packed {
    cds_pkg::tag_t  tag;
    cds_pkg::word_t value;
    logic           last;
  } due_result_t;

  class sorted_choice_checker;
    cds_pkg::word_t known_values[$];
    cds_pkg::word_t picked_values[$];
    due_result_t    due_results[$];
    int             errors;
    int             tag_count[4];

    function new();
      errors = 0;
      foreach (tag_count[n]) tag_count[n] = 0;
    endfunction

    function void apply_word(cds_pkg::func_t f, cds_pkg::word_t v);
      due_result_t    r;
      cds_pkg::word_t order[$];
      cds_pkg::word_t cur;
      int             i;
      int             j;
      bit             known;
      r.tag   = cds_pkg::TAG_OK;
      r.value = v;
      r.last  = 1'b1;
      case (f)
        cds_pkg::FUNC_LIST: begin
          if (known_values.size() >= LIST_CAP) r.tag = cds_pkg::TAG_FULL;
          else known_values.push_back(v);
          due_results.push_back(r);
        end
        cds_pkg::FUNC_CHOICE: begin
          known = 1'b0;
          for (i = 0; i < known_values.size(); i++)
            if (known_values[i] == v) known = 1'b1;
          if (!known) r.tag = cds_pkg::TAG_NOT_IN_LIST;
          else if (picked_values.size() >= CHOICE_CAP) r.tag = cds_pkg::TAG_FULL;
          else picked_values.push_back(v);
          due_results.push_back(r);
        end
        cds_pkg::FUNC_FINISH: begin
          order = picked_values;
          for (i = 1; i < order.size(); i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && order[j-1] < cur) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = cur;
          end
          for (i = 0; i < order.size(); i++) begin
            r.tag   = cds_pkg::TAG_SORTED;
            r.value = order[i];
            r.last  = (i == order.size() - 1);
            due_results.push_back(r);
          end
          picked_values.delete();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_word(cds_pkg::tag_t t, cds_pkg::word_t v, logic l);
      due_result_t e;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result tag=%0d value=%0d last=%0b", t, v, l);
        return;
      end
      e = due_results.pop_front();
      if (e.tag !== t || e.value !== v || e.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected tag=%0d value=%0d last=%0b, got tag=%0d value=%0d last=%0b",
                   e.tag, e.value, e.last, t, v, l);
      end else begin
        tag_count[t]++;
      end
    endfunction
  endclass

endpackage

FILE: test/tb_checked_choice_descending_sorter_top.sv
// Testbench for checked_choice_descending_sorter_top: directed and random words
// under several idle mixes, checked against a scoreboard prediction.
// Depends on cds_pkg, cds_in_if, cds_out_if and cds_tb_pkg.
module tb_checked_choice_descending_sorter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 120;
  localparam int MIX_WORDS    = 110;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int words_sent     = 0;
  int finishes_sent  = 0;

  cds_tb_pkg::sorted_choice_checker sb;

  cds_in_if  in_ch ();
  cds_out_if out_ch ();

  checked_choice_descending_sorter_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        sb.apply_word(in_ch.func, in_ch.value_in);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_word(out_ch.tag, out_ch.value_out, out_ch.last);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("checked_choice_descending_sorter_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(cds_pkg::func_t f, cds_pkg::word_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.value_in <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    if (f == cds_pkg::FUNC_FINISH) finishes_sent++;
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  function automatic cds_pkg::word_t list_value();
    cds_pkg::word_t v;
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 3))
           0: v = 32'h8000_0000;
           1: v = 32'h7fff_ffff;
           2: v = 32'h0000_0000;
           default: v = 32'hffff_ffff;
         endcase
      1, 2: v = $signed($urandom_range(16)) - 8;
      3: if (sb.known_values.size() > 0)
           v = sb.known_values[$urandom_range(sb.known_values.size() - 1)];
         else
           v = $urandom;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic cds_pkg::word_t choice_value();
    cds_pkg::word_t v;
    int             pick;
    pick = $urandom_range(0, 9);
    if (sb.known_values.size() == 0 || pick == 8) begin
      v = $urandom;
    end else begin
      v = sb.known_values[$urandom_range(sb.known_values.size() - 1)];
      if (pick == 9) v = v + 1;
    end
    return v;
  endfunction

  task automatic run_directed();
    send_word(cds_pkg::FUNC_FINISH, 32'h0000_0000);
    send_word(cds_tb_pkg::FUNC_UNUSED, 32'h1234_5678);
    send_word(cds_pkg::FUNC_CHOICE, 32'h0000_0000);
    send_word(cds_pkg::FUNC_LIST, 32'h8000_0000);
    send_word(cds_pkg::FUNC_LIST, 32'h7fff_ffff);
    send_word(cds_pkg::FUNC_LIST, 32'h0000_0000);
    send_word(cds_pkg::FUNC_LIST, 32'hffff_ffff);
    send_word(cds_pkg::FUNC_LIST, 32'h0000_0001);
    send_word(cds_pkg::FUNC_LIST, 32'h7fff_ffff);
    send_word(cds_pkg::FUNC_CHOICE, 32'h7fff_ffff);
    send_word(cds_pkg::FUNC_CHOICE, 32'h8000_0000);
    send_word(cds_pkg::FUNC_CHOICE, 32'h0000_0001);
    send_word(cds_pkg::FUNC_CHOICE, 32'hffff_ffff);
    send_word(cds_pkg::FUNC_CHOICE, 32'h0000_0000);
    send_word(cds_pkg::FUNC_CHOICE, 32'h7fff_ffff);
    send_word(cds_pkg::FUNC_CHOICE, 32'h0000_0007);
    send_word(cds_pkg::FUNC_FINISH, 32'hffff_ffff);
    send_word(cds_pkg::FUNC_FINISH, 32'h0000_0000);
    hold_until_drained();
  endtask

  task automatic run_random(int quota);
    int done;
    int k;
    done = 0;
    while (done < quota) begin
      if (sb.known_values.size() < cds_tb_pkg::LIST_CAP) k = $urandom_range(1, 4);
      else k = ($urandom_range(0, 3) == 0);
      repeat (k) send_word(cds_pkg::FUNC_LIST, list_value());
      done += k;
      if ($urandom_range(0, 7) == 0) k = $urandom_range(34, 40);
      else k = $urandom_range(1, 10);
      repeat (k) send_word(cds_pkg::FUNC_CHOICE, choice_value());
      done += k;
      case ($urandom_range(0, 9))
        0: send_word(cds_tb_pkg::FUNC_UNUSED, $urandom);
        1: send_word(cds_pkg::FUNC_FINISH, $urandom);
        default: begin
        end
      endcase
      send_word(cds_pkg::FUNC_FINISH, $urandom);
      done++;
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end
  endtask

  initial begin
    sb = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= cds_pkg::FUNC_LIST;
    in_ch.value_in <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      run_random(MIX_WORDS);
      hold_until_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d finishes) over four idle mixes; list holds %0d values",
             words_sent, finishes_sent, sb.known_values.size());
    $display("Results: %0d accepted, %0d not in list, %0d full, %0d sorted; %0d errors",
             sb.tag_count[cds_pkg::TAG_OK], sb.tag_count[cds_pkg::TAG_NOT_IN_LIST],
             sb.tag_count[cds_pkg::TAG_FULL], sb.tag_count[cds_pkg::TAG_SORTED], sb.errors);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("checked_choice_descending_sorter_top test passed");
    end else begin
      $display("checked_choice_descending_sorter_top test failed");
    end
    $finish;
  end

endmodule
